### sv/gww_pkg.sv
// Shared types and constants for the greedy word wrap block.
// Used by the controller, the datapath and the top level; no dependencies.
package gww_pkg;

  localparam int WORD_BUFFER = 48;

  localparam logic [5:0] LINE_WIDTH_RESET = 6'd47;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Output byte source selected by the controller
  localparam logic [1:0] SRC_PRE  = 2'd0;
  localparam logic [1:0] SRC_WORD = 2'd1;
  localparam logic [1:0] SRC_NL   = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       text_done;
    logic       word_too_long;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [1:0] src;
    logic       last;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic pre_en;
    logic word_en;
    logic para_en;
    logic fin_en;
    logic word_last;
    logic out_free;
  } status_t;

endpackage

### sv/gww_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/gww_ctrl.sv
// Sequencer for the word wrap block: accepts one byte, then walks the
// emission phases of its plan. Depends on gww_pkg.
module gww_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gww_pkg::status_t status,
  output gww_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_WORD  = 3'd3;
  localparam logic [2:0] S_PARA1 = 3'd4;
  localparam logic [2:0] S_PARA2 = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] after;
  logic       emitting;

  // First enabled phase in emission order
  function automatic logic [2:0] pick(input logic p, input logic w,
                                      input logic pa, input logic f);
    logic [2:0] s;
    if (p) begin
      s = S_PRE;
    end else if (w) begin
      s = S_WORD;
    end else if (pa) begin
      s = S_PARA1;
    end else if (f) begin
      s = S_FIN;
    end else begin
      s = S_IDLE;
    end
    return s;
  endfunction

  always_comb begin
    state_nxt = state_r;
    after     = S_IDLE;
    emitting  = 1'b0;
    cmd       = '0;
    cmd.src   = gww_pkg::SRC_NL;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // word store read settles here
        state_nxt = pick(status.pre_en, status.word_en, status.para_en, status.fin_en);
      end
      S_PRE: begin
        emitting = 1'b1;
        cmd.src  = gww_pkg::SRC_PRE;
        after    = pick(1'b0, status.word_en, status.para_en, status.fin_en);
      end
      S_WORD: begin
        emitting = 1'b1;
        cmd.src  = gww_pkg::SRC_WORD;
        after    = status.word_last ? pick(1'b0, 1'b0, status.para_en, status.fin_en)
                                    : S_WORD;
      end
      S_PARA1: begin
        emitting = 1'b1;
        after    = S_PARA2;
      end
      S_PARA2: begin
        emitting = 1'b1;
        after    = pick(1'b0, 1'b0, 1'b0, status.fin_en);
      end
      S_FIN: begin
        emitting = 1'b1;
        cmd.done = 1'b1;
        after    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emitting && status.out_free) begin
      cmd.emit  = 1'b1;
      cmd.last  = (after == S_IDLE);
      state_nxt = after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### sv/gww_dp.sv
// Datapath of the word wrap block: line/word state, emission plan, word
// store, output register and the line width register. Depends on gww_pkg, gww_ram.
module gww_dp #(
  parameter int WORD_BUFFER = gww_pkg::WORD_BUFFER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gww_pkg::in_item_t  in_data,
  input  gww_pkg::cmd_t      cmd,
  output gww_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output gww_pkg::out_item_t out_data,
  input  logic               cfg_wr,
  input  logic               cfg_sel0,
  input  logic [5:0]         cfg_wdata,
  output logic [5:0]         cfg_rdata
);

  localparam int AW = $clog2(WORD_BUFFER);
  localparam int NW = $clog2(WORD_BUFFER + 1);
  localparam int SW = AW + 1;
  localparam int EW = (AW > 6) ? AW : 6;

  logic [5:0]    lw_r;
  logic [AW-1:0] ll_r, ll_nxt;
  logic [AW-1:0] wl_r, wl_nxt;
  logic [1:0]    nr_r, nr_nxt;
  logic          st_r, st_nxt;
  logic          err_r, err_nxt;

  logic          pre_en_r, pre_en_nxt;
  logic [7:0]    pre_ch_r, pre_ch_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          para_r, para_nxt;
  logic          fin_r;

  logic [AW-1:0] idx_r, idx_nxt;
  logic          word_last;
  logic [7:0]    rdata;

  logic          out_valid_r, out_valid_nxt;
  gww_pkg::out_item_t out_data_r;
  logic [7:0]    out_ch;

  logic [7:0]    c;
  logic          fin;
  logic          ws;
  logic          full;
  logic          we;
  logic          st_e;
  logic [AW-1:0] wl_e;
  logic [EW-1:0] w_ext;
  logic [AW-1:0] w;
  logic [SW-1:0] sum;

  assign c   = in_data.char_in;
  assign fin = in_data.text_end;

  // Effective width: zero counts as one, capped below the buffer size
  always_comb begin
    if (lw_r == '0) begin
      w_ext = EW'(1);
    end else if (EW'(lw_r) > EW'(WORD_BUFFER - 1)) begin
      w_ext = EW'(WORD_BUFFER - 1);
    end else begin
      w_ext = EW'(lw_r);
    end
    w = w_ext[AW-1:0];
  end

  assign ws   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign full = !ws && !st_r && (wl_r == AW'(WORD_BUFFER - 1));

  always_comb begin
    if (ws) begin
      wl_e = wl_r;
      st_e = st_r;
    end else begin
      wl_e = (st_r || full) ? '0 : wl_r + AW'(1);
      st_e = st_r || full;
    end
    sum = SW'(ll_r) + SW'(1) + SW'(wl_e);

    pre_en_nxt = 1'b0;
    pre_ch_nxt = c;
    n_nxt      = '0;
    para_nxt   = 1'b0;
    ll_nxt     = ll_r;
    wl_nxt     = wl_r;
    st_nxt     = st_r;
    err_nxt    = err_r;
    nr_nxt     = nr_r;
    we         = 1'b0;

    if (!ws) begin
      nr_nxt = '0;
      if (st_r) begin
        pre_en_nxt = 1'b1;
      end else begin
        we = 1'b1;
        if (full) begin
          // buffer overflow: dump it and stream the rest of the word
          err_nxt    = 1'b1;
          pre_en_nxt = (ll_r != '0);
          pre_ch_nxt = gww_pkg::CH_NL;
          n_nxt      = NW'(WORD_BUFFER);
          wl_nxt     = '0;
          st_nxt     = 1'b1;
        end else begin
          wl_nxt = wl_r + AW'(1);
        end
      end
    end

    // Place the pending word
    if (ws || fin) begin
      if (st_e) begin
        ll_nxt = w;
        st_nxt = 1'b0;
      end else if (wl_e != '0) begin
        n_nxt  = NW'(wl_e);
        wl_nxt = '0;
        if (wl_e > w) begin
          err_nxt    = 1'b1;
          pre_en_nxt = (ll_r != '0);
          pre_ch_nxt = gww_pkg::CH_NL;
          ll_nxt     = w;
        end else if (ll_r == '0) begin
          ll_nxt = wl_e;
        end else if (sum <= SW'(w)) begin
          pre_en_nxt = 1'b1;
          pre_ch_nxt = gww_pkg::CH_SPACE;
          ll_nxt     = sum[AW-1:0];
        end else begin
          pre_en_nxt = 1'b1;
          pre_ch_nxt = gww_pkg::CH_NL;
          ll_nxt     = wl_e;
        end
      end
    end

    if (ws && (c == gww_pkg::CH_NL)) begin
      if (nr_r == 2'd1) begin
        nr_nxt   = 2'd2;
        para_nxt = (ll_nxt != '0);
        ll_nxt   = '0;
      end else if (nr_r == 2'd0) begin
        nr_nxt = 2'd1;
      end
    end

    if (fin) begin
      ll_nxt = '0;
      nr_nxt = '0;
      wl_nxt = '0;
      st_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_r     <= '0;
      wl_r     <= '0;
      nr_r     <= '0;
      st_r     <= 1'b0;
      err_r    <= 1'b0;
      pre_en_r <= 1'b0;
      n_r      <= '0;
      para_r   <= 1'b0;
      fin_r    <= 1'b0;
    end else if (cmd.take) begin
      ll_r     <= ll_nxt;
      wl_r     <= wl_nxt;
      nr_r     <= nr_nxt;
      st_r     <= st_nxt;
      err_r    <= err_nxt;
      pre_en_r <= pre_en_nxt;
      n_r      <= n_nxt;
      para_r   <= para_nxt;
      fin_r    <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pre_ch_r <= pre_ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= gww_pkg::LINE_WIDTH_RESET;
    end else if (cfg_wr && cfg_sel0) begin
      lw_r <= cfg_wdata;
    end
  end

  assign cfg_rdata = cfg_sel0 ? lw_r : '0;

  // Read address is idx_nxt so the registered RAM data tracks idx_r
  assign word_last = ((NW'(idx_r) + NW'(1)) == n_r);

  always_comb begin
    if (cmd.take) begin
      idx_nxt = '0;
    end else if (cmd.emit && (cmd.src == gww_pkg::SRC_WORD) && !word_last) begin
      idx_nxt = idx_r + AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  gww_ram #(
    .WIDTH (8),
    .DEPTH (WORD_BUFFER)
  ) u_word_store (
    .clk   (clk),
    .we    (we && cmd.take),
    .waddr (wl_r),
    .wdata (c),
    .raddr (idx_nxt),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.src)
      gww_pkg::SRC_PRE:  out_ch = pre_ch_r;
      gww_pkg::SRC_WORD: out_ch = rdata;
      gww_pkg::SRC_NL:   out_ch = gww_pkg::CH_NL;
      default:           out_ch = gww_pkg::CH_NL;
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.char_out      <= out_ch;
      out_data_r.run_last      <= cmd.last;
      out_data_r.text_done     <= cmd.done;
      out_data_r.word_too_long <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.pre_en    = pre_en_r;
  assign status.word_en   = (n_r != '0);
  assign status.para_en   = para_r;
  assign status.fin_en    = fin_r;
  assign status.word_last = word_last;
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

### sv/greedy_word_wrap.sv
// Greedy word wrap: one input byte at a time, wrapped text out one byte per result.
// A byte is accepted in S_IDLE, then walks S_LOAD and its emission states; in_stall
// holds off new bytes until S_IDLE. Results pass the output register, one byte
// per cycle unless out_stall holds it, from the single read port of the word store.
// Reset (rst_n, synchronous) clears line, word and error state and sets
// line_width to 47; the word store needs no clearing pass.
module greedy_word_wrap #(
  parameter int WORD_BUFFER = gww_pkg::WORD_BUFFER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gww_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gww_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  gww_pkg::cmd_t    cmd;
  gww_pkg::status_t status;
  logic             cfg_wr;
  logic [5:0]       cfg_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {26'd0, cfg_rdata};

  gww_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gww_dp #(
    .WORD_BUFFER (WORD_BUFFER)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr    (cfg_wr),
    .cfg_sel0  (cfg_paddr[2] == 1'b0),
    .cfg_wdata (cfg_pwdata[5:0]),
    .cfg_rdata (cfg_rdata)
  );

endmodule
